// ===== src/cld_pkg.sv =====
// Shared types, constants and fixed-point helpers for the LDL^T factor block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cld_pkg;

  localparam int SIZE_W      = 4;
  localparam int DIM_DEFAULT = 8;
  localparam int ACC_W       = 36;

  typedef enum logic [3:0] {
    B_LOAD,
    B_AREAD,
    B_AINIT,
    B_KRD,
    B_KM1,
    B_KM2,
    B_KACC,
    B_KDONE,
    B_DIV,
    B_ROOT,
    B_RWAIT,
    B_ORD,
    B_OMUL,
    B_OSET,
    B_OWAIT
  } back_state_t;

  // floor(p / 2^16), saturated to 32 bits signed
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    logic signed [47:0] s;
    s = p[63:16];
    if (s > 48'sd2147483647) begin
      qsat = 32'sh7fffffff;
    end else if (s < -48'sd2147483648) begin
      qsat = 32'sh80000000;
    end else begin
      qsat = s[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] a);
    if (a > 36'sd2147483647) begin
      sat_acc = 32'sh7fffffff;
    end else if (a < -36'sd2147483648) begin
      sat_acc = 32'sh80000000;
    end else begin
      sat_acc = a[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/cld_front.sv =====
// Front end: takes element beats, tracks row/column and flags the last one.
// Depends on cld_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cld_front import cld_pkg::*; #(
  parameter int MAX_DIM = DIM_DEFAULT,
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int EW = 32 + 2 * IW + 1 + SIZE_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              matrix_size_we,
  input  wire logic [SIZE_W-1:0] matrix_size,
  input  wire logic              element_valid,
  output logic                   element_ready,
  input  wire logic [31:0]       element_value,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output logic [EW-1:0]          q_data
);

  logic [SIZE_W-1:0] n;
  logic [IW-1:0]     row;
  logic [IW-1:0]     col;
  logic              col_end;
  logic              last;

  assign col_end       = (SIZE_W'(col) == n - SIZE_W'(1));
  assign last          = col_end && (SIZE_W'(row) == n - SIZE_W'(1));
  assign q_valid       = element_valid;
  assign element_ready = q_ready;
  assign q_data        = {element_value, row, col, last, n};

  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= SIZE_W'(MAX_DIM);
      row <= '0;
      col <= '0;
    end else if (matrix_size_we) begin
      if (matrix_size == '0) begin
        n <= SIZE_W'(1);
      end else if (matrix_size > SIZE_W'(MAX_DIM)) begin
        n <= SIZE_W'(MAX_DIM);
      end else begin
        n <= matrix_size;
      end
      row <= '0;
      col <= '0;
    end else if (element_valid && q_ready) begin
      if (col_end) begin
        col <= '0;
        row <= last ? '0 : row + IW'(1);
      end else begin
        col <= col + IW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/cld_fifo.sv =====
// Short queue between the front and back ends.
// Depends on cld_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cld_fifo import cld_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  logic [WIDTH-1:0] mem [4];
  logic [1:0]       wptr;
  logic [1:0]       rptr;
  logic [2:0]       cnt;
  logic             push;
  logic             pop;

  assign in_ready  = (cnt != 3'd4);
  assign out_valid = (cnt != 3'd0);
  assign out_data  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) rptr <= rptr + 2'd1;
      cnt <= cnt + 3'(push) - 3'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== src/cld_div.sv =====
// Iterative signed divider: (num * 2^16) / den, truncated, saturated to 32 bits.
// One quotient bit per cycle. Depends on cld_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cld_div import cld_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [ACC_W-1:0] num,
  input  wire logic signed [31:0]      den,
  output logic                         done,
  output logic signed [31:0]           quot
);

  localparam int QW = ACC_W + 16;

  logic          busy;
  logic [5:0]    cnt;
  logic          neg;
  logic [QW-1:0] dq;
  logic [31:0]   rem;
  logic [31:0]   dmag;
  logic [32:0]   rem_sh;
  logic          ge;
  logic [32:0]   rem_sub;
  logic [ACC_W-1:0] nmag;

  assign nmag    = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign rem_sh  = {rem, dq[QW-1]};
  assign ge      = (rem_sh >= {1'b0, dmag});
  assign rem_sub = rem_sh - {1'b0, dmag};

  always_comb begin
    if (!neg) begin
      quot = (dq > QW'(32'h7fffffff)) ? 32'sh7fffffff : dq[31:0];
    end else begin
      quot = (dq > QW'(33'h080000000)) ? 32'sh80000000 : -dq[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= num[ACC_W-1] ^ den[31];
        dq   <= {nmag, 16'd0};
        rem  <= '0;
        dmag <= den[31] ? -den : den;
      end else if (busy) begin
        rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
        dq  <= {dq[QW-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/cld_sqrt.sv =====
// Iterative integer square root of d * 2^16, zero for d <= 0.
// One root bit per cycle. Depends on cld_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cld_sqrt import cld_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] d,
  output logic                    done,
  output logic [31:0]             root
);

  logic        busy;
  logic [47:0] v;
  logic [47:0] r;
  logic [47:0] bitv;
  logic [47:0] t;

  assign t    = r + bitv;
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        v    <= (d > 32'sd0) ? {1'b0, d[30:0], 16'd0} : '0;
        r    <= '0;
        bitv <= 48'd1 << 46;
      end else if (busy) begin
        if (bitv == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (v >= t) begin
            v <= v - t;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/cld_back.sv =====
// Back end: stores the matrix, runs the LDL^T sequencer and emits L*sqrt(D).
// Depends on cld_pkg, cld_div, cld_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module cld_back import cld_pkg::*; #(
  parameter int MAX_DIM = DIM_DEFAULT,
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int AW = 2 * IW,
  localparam int EW = 32 + 2 * IW + 1 + SIZE_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire logic [EW-1:0] q_data,
  output logic               result_valid,
  input  wire logic          result_ready,
  output logic [31:0]        result_value,
  output logic               last_result
);

  back_state_t state;
  back_state_t state_next;

  logic signed [31:0] amem [1 << AW];
  logic signed [31:0] lmem [1 << AW];
  logic signed [31:0] dreg [MAX_DIM];
  logic signed [31:0] sreg [MAX_DIM];

  logic signed [31:0]      a_rd;
  logic signed [31:0]      la_rd;
  logic signed [31:0]      lb_rd;
  logic signed [ACC_W-1:0] acc;
  logic signed [63:0]      prod;
  logic signed [31:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic [SIZE_W-1:0]       n;
  logic [IW-1:0]           i;
  logic [IW-1:0]           j;
  logic [IW-1:0]           k;
  logic [IW-1:0]           didx;
  logic signed [31:0]      d_sel;
  logic [AW-1:0]           l1_addr;

  logic [31:0]       e_value;
  logic [IW-1:0]     e_row;
  logic [IW-1:0]     e_col;
  logic              e_last;
  logic [SIZE_W-1:0] e_size;

  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_quot;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;
  logic               i_end;
  logic               j_end;
  logic               j_eq_i;

  assign {e_value, e_row, e_col, e_last, e_size} = q_data;

  assign i_end   = (SIZE_W'(i) == n - SIZE_W'(1));
  assign j_end   = (SIZE_W'(j) == n - SIZE_W'(1));
  assign j_eq_i  = (j == i);
  assign didx    = (state == B_KM2) ? k : j;
  assign d_sel   = dreg[didx];
  assign l1_addr = (state == B_ORD || state == B_OMUL) ? {i, j} : {i, k};

  cld_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (d_sel),
    .done  (div_done),
    .quot  (div_quot)
  );

  cld_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .d     (d_sel),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_comb begin
    mul_a = la_rd;
    mul_b = lb_rd;
    case (state)
      B_KM2: begin
        mul_a = qsat(prod);
        mul_b = d_sel;
      end
      B_OMUL: begin
        mul_b = sreg[j];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    case (state)
      B_LOAD: begin
        q_ready = 1'b1;
        if (q_valid && e_last) state_next = B_AREAD;
      end
      B_AREAD: state_next = B_AINIT;
      B_AINIT: state_next = (j == '0) ? B_KDONE : B_KRD;
      B_KRD:   state_next = B_KM1;
      B_KM1:   state_next = B_KM2;
      B_KM2:   state_next = B_KACC;
      B_KACC:  state_next = (k == j - IW'(1)) ? B_KDONE : B_KRD;
      B_KDONE: begin
        if (j_eq_i) begin
          state_next = i_end ? B_ROOT : B_AREAD;
        end else if (d_sel == '0) begin
          state_next = B_AREAD;
        end else begin
          div_start  = 1'b1;
          state_next = B_DIV;
        end
      end
      B_DIV: if (div_done) state_next = B_AREAD;
      B_ROOT: begin
        sqrt_start = 1'b1;
        state_next = B_RWAIT;
      end
      B_RWAIT: if (sqrt_done) state_next = j_end ? B_ORD : B_ROOT;
      B_ORD:   state_next = B_OMUL;
      B_OMUL:  state_next = B_OSET;
      B_OSET:  state_next = B_OWAIT;
      B_OWAIT: begin
        if (result_ready) state_next = (i_end && j_end) ? B_LOAD : B_ORD;
      end
      default: state_next = B_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      amem[{e_row, e_col}] <= e_value;
    end
    a_rd <= amem[{i, j}];
  end

  always_ff @(posedge clk) begin
    if (state == B_KDONE && !j_eq_i && d_sel == '0) begin
      lmem[{i, j}] <= '0;
    end else if (state == B_DIV && div_done) begin
      lmem[{i, j}] <= div_quot;
    end
    la_rd <= lmem[l1_addr];
    lb_rd <= lmem[{j, k}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      case (state)
        B_LOAD: begin
          if (q_valid && e_last) begin
            n <= e_size;
            i <= '0;
            j <= '0;
          end
        end
        B_AINIT: begin
          acc <= ACC_W'(a_rd);
          k   <= '0;
        end
        B_KM1, B_KM2: prod <= mul_a * mul_b;
        B_KACC: begin
          acc <= acc - ACC_W'(qsat(prod));
          k   <= k + IW'(1);
        end
        B_KDONE: begin
          if (j_eq_i) begin
            dreg[i] <= sat_acc(acc);
            j       <= '0;
            if (!i_end) i <= i + IW'(1);
          end else if (d_sel == '0) begin
            j <= j + IW'(1);
          end
        end
        B_DIV: if (div_done) j <= j + IW'(1);
        B_RWAIT: begin
          if (sqrt_done) begin
            sreg[j] <= sqrt_root;
            if (j_end) begin
              i <= '0;
              j <= '0;
            end else begin
              j <= j + IW'(1);
            end
          end
        end
        B_OMUL: prod <= mul_a * mul_b;
        B_OSET: begin
          result_valid <= 1'b1;
          last_result  <= i_end && j_end;
          if (j > i) begin
            result_value <= '0;
          end else if (j_eq_i) begin
            result_value <= sreg[j];
          end else begin
            result_value <= qsat(prod);
          end
        end
        B_OWAIT: begin
          if (result_ready) begin
            result_valid <= 1'b0;
            if (j_end) begin
              j <= '0;
              i <= i + IW'(1);
            end else begin
              j <= j + IW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/cholesky_ldl_decomposition.sv =====
// Top level of the LDL^T factor block: front end, queue and back end.
// Depends on cld_pkg, cld_front, cld_fifo, cld_back.
//
// Elements of an n x n Q16.16 matrix load row-major, one beat per cycle while
// the four-entry queue has room; after the last element the back end factors
// the matrix and streams B = L*sqrt(D) row-major, last_result on the final beat.
// The back end's sequencer sets the pace: each correction term steps through
// B_KRD, B_KM1, B_KM2 and B_KACC on the shared multiplier, each lower-triangle
// entry adds B_AREAD, B_AINIT and B_KDONE, each nonzero-pivot L entry a divide,
// each root a square-root run, each result beat B_ORD, B_OMUL, B_OSET, B_OWAIT.
// The back end takes no new element until the last result beat is accepted.
`timescale 1ns / 1ps
`default_nettype none
module cholesky_ldl_decomposition import cld_pkg::*; #(
  parameter int MAX_DIM = DIM_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              matrix_size_we,
  input  wire logic [SIZE_W-1:0] matrix_size,
  input  wire logic              element_valid,
  output logic                   element_ready,
  input  wire logic [31:0]       element_value,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output logic [31:0]            result_value,
  output logic                   last_result
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int EW = 32 + 2 * IW + 1 + SIZE_W;

  logic          f_valid;
  logic          f_ready;
  logic [EW-1:0] f_data;
  logic          b_valid;
  logic          b_ready;
  logic [EW-1:0] b_data;

  cld_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk            (clk),
    .rst            (rst),
    .matrix_size_we (matrix_size_we),
    .matrix_size    (matrix_size),
    .element_valid  (element_valid),
    .element_ready  (element_ready),
    .element_value  (element_value),
    .q_valid        (f_valid),
    .q_ready        (f_ready),
    .q_data         (f_data)
  );

  cld_fifo #(.WIDTH(EW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  cld_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (b_valid),
    .q_ready      (b_ready),
    .q_data       (b_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_value (result_value),
    .last_result  (last_result)
  );

endmodule
`default_nettype wire

// ===== src/cld_checker.sv =====
// Port-level assertions for the LDL^T factor block, bound to the top level.
// Depends on cld_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cld_checker import cld_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              element_valid,
  input wire logic              element_ready,
  input wire logic [31:0]       element_value,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire logic [31:0]       result_value,
  input wire logic              last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_value)
      && $stable(last_result))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_gap_after_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready |=> !result_valid)
    else $error("result beats issued back to back");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    element_valid && !element_ready |=> element_valid && $stable(element_value))
    else $error("element beat changed while stalled");

endmodule

bind cholesky_ldl_decomposition cld_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .element_valid  (element_valid),
  .element_ready  (element_ready),
  .element_value  (element_value),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .result_value   (result_value),
  .last_result    (last_result)
);
`default_nettype wire
